### hdl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the positional array table.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int ELEM_W  = 32;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;

  typedef enum logic [1:0] {
    OP_TRAVERSE = 2'd0,
    OP_INSERT   = 2'd1,
    OP_DELETE   = 2'd2,
    OP_SEARCH   = 2'd3
  } pat_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } pat_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } pat_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // item taken this cycle
    logic scan;    // taken item needs a pass over the cells
    logic step;    // one rotate and compare step
    logic trav;    // pass emits every element
    logic load;    // load the output register
  } pat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;      // no stored elements
    logic step_last;  // current step is the final one of the pass
  } pat_sts_t;

endpackage

### hdl/pat_ctrl.sv
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer: handshakes, immediate operations and the rotate pass.
// ----------------------------------------------------------------------------
module pat_ctrl import pat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  pat_sts_t   sts,
  output pat_cmd_t   cmd
);

  pat_state_t state_r, state_nxt;
  logic       trav_r, trav_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  pat_op_t    op;

  assign op        = pat_op_t'(in_operation);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trav_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      trav_r      <= trav_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    trav_nxt  = trav_r;
    cmd       = '0;
    cmd.trav  = trav_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          cmd.accept = 1'b1;
          cmd.scan   = (op == OP_TRAVERSE || op == OP_SEARCH) && !sts.empty;
          cmd.load   = !cmd.scan;
          if (cmd.scan) begin
            state_nxt = S_SCAN;
            trav_nxt  = (op == OP_TRAVERSE);
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          cmd.step = 1'b1;
          cmd.load = trav_r || sts.step_last;
          if (sts.step_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load || (out_valid_r && out_stall);
  end

`ifndef NO_ASSERTIONS
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> in_stall)
    else $error("input taken during a pass");
  a_imm_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && !cmd.scan |=> out_valid_r)
    else $error("single-cycle operation gave no result");
  a_scan_enter: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && cmd.scan |=> state_r == S_SCAN)
    else $error("pass not started");
`endif

endmodule

### hdl/pat_dp.sv
// ----------------------------------------------------------------------------
// pat_dp
// Register cell array, element count, scan counter and output register.
// ----------------------------------------------------------------------------
module pat_dp import pat_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pat_cmd_t                  cmd,
  output pat_sts_t                  sts,
  input  logic [1:0]                in_operation,
  input  logic signed [ELEM_W-1:0]  in_value,
  input  logic [POS_W-1:0]          in_position,
  output logic [2:0]                out_status,
  output logic signed [ELEM_W-1:0]  out_element,
  output logic [INDEX_W-1:0]        out_index,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_last
);

  logic signed [ELEM_W-1:0] cell_r [CAPACITY];
  logic [COUNT_W-1:0]       count_r, count_nxt, count_m1;
  logic [INDEX_W-1:0]       scan_idx_r, found_idx_r;
  logic                     found_r;
  logic signed [ELEM_W-1:0] key_r;
  logic                     ins_ok, del_ok, rot;
  logic                     full, match_now, hit;
  logic [INDEX_W-1:0]       hit_idx;
  pat_status_t              imm_status;
  pat_op_t                  op;

  pat_status_t              status_r;
  logic signed [ELEM_W-1:0] element_r;
  logic [INDEX_W-1:0]       index_r;
  logic                     last_r;

  assign op        = pat_op_t'(in_operation);
  assign count_m1  = count_r - COUNT_W'(1);
  assign full      = count_r >= COUNT_W'(CAPACITY);
  assign sts.empty = (count_r == '0);
  assign sts.step_last = ({1'b0, scan_idx_r} == count_m1);
  assign rot       = cmd.step;

  // immediate operation checks
  always_comb begin
    imm_status = ST_OK;
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    count_nxt  = count_r;
    unique case (op)
      OP_INSERT: begin
        if (full)                      imm_status = ST_FULL;
        else if (in_position > count_r) imm_status = ST_BADPOS;
        else begin
          ins_ok    = cmd.accept && !cmd.scan;
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (count_r == '0)              imm_status = ST_EMPTY;
        else if (in_position >= count_r) imm_status = ST_BADPOS;
        else begin
          del_ok    = cmd.accept && !cmd.scan;
          count_nxt = count_m1;
        end
      end
      OP_TRAVERSE, OP_SEARCH: imm_status = ST_EMPTY;
      default: imm_status = ST_EMPTY;
    endcase
  end

  // cells: shift up on insert, down on delete, rotate toward slot 0 on a pass
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int UP = (g == CAPACITY - 1) ? g : g + 1;
    localparam int DN = (g == 0) ? 0 : g - 1;
    always_ff @(posedge clk) begin
      if (ins_ok) begin
        if (COUNT_W'(g) > in_position && COUNT_W'(g) <= count_r) cell_r[g] <= cell_r[DN];
        else if (COUNT_W'(g) == in_position)                     cell_r[g] <= in_value;
      end else if (del_ok) begin
        if (COUNT_W'(g) >= in_position) cell_r[g] <= cell_r[UP];
      end else if (rot) begin
        if (COUNT_W'(g) == count_m1)     cell_r[g] <= cell_r[0];
        else if (COUNT_W'(g) < count_m1) cell_r[g] <= cell_r[UP];
      end
    end
  end

  // element count
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (ins_ok || del_ok) count_r <= count_nxt;
  end

  // search compare on the head cell
  assign match_now = !found_r && (cell_r[0] == key_r);
  assign hit       = found_r || match_now;
  assign hit_idx   = found_r ? found_idx_r : scan_idx_r;

  // scan counter and first-match record
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r      <= in_value;
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.step) begin
      scan_idx_r <= scan_idx_r + INDEX_W'(1);
      if (match_now) begin
        found_r     <= 1'b1;
        found_idx_r <= scan_idx_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.accept) begin
        status_r  <= imm_status;
        element_r <= '0;
        index_r   <= '0;
        last_r    <= 1'b1;
      end else if (cmd.trav) begin
        status_r  <= ST_OK;
        element_r <= cell_r[0];
        index_r   <= scan_idx_r;
        last_r    <= sts.step_last;
      end else begin
        status_r  <= hit ? ST_OK : ST_NOTFOUND;
        element_r <= hit ? key_r : '0;
        index_r   <= hit ? hit_idx : '0;
        last_r    <= 1'b1;
      end
    end
  end

  assign out_status  = status_r;
  assign out_element = element_r;
  assign out_index   = index_r;
  assign out_count   = count_r;
  assign out_last    = last_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("element count above capacity");
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> ({1'b0, scan_idx_r} < count_r))
    else $error("scan step beyond stored elements");
  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |-> !full)
    else $error("insert into a full table");
`endif

endmodule

### hdl/positional_array_table.sv
// ----------------------------------------------------------------------------
// positional_array_table
// Packed array of signed elements with insert, delete, search and traverse.
// ----------------------------------------------------------------------------
// Insert and delete shift the register cell array as the item is taken, and
// they and every error or empty result are answered from the output register
// with no pass. Traverse and search rotate the stored elements through slot 0
// once, one element per cycle while the output is not stalled: the item is
// taken, then one step is made per element; traverse emits one element each
// step, search reports on the final step. One item is worked on at a time; the
// next is taken no earlier than the cycle in which the last result of the
// previous one leaves the output register.
module positional_array_table import pat_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic signed [ELEM_W-1:0]  in_value,
  input  logic [POS_W-1:0]          in_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_status,
  output logic signed [ELEM_W-1:0]  out_element,
  output logic [INDEX_W-1:0]        out_index,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_last
);

  pat_cmd_t cmd;
  pat_sts_t sts;

  // sequencer
  pat_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // cells and output register
  pat_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_position  (in_position),
    .out_status   (out_status),
    .out_element  (out_element),
    .out_index    (out_index),
    .out_count    (out_count),
    .out_last     (out_last)
  );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional array table. A tracker class keeps
// its own copy of the stored elements and the count, works out the results of
// every accepted item and compares each returned result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pat_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int ITEM_TOTAL  = 450;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_MAX  = 100;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [ELEM_W-1:0] element;
    logic [INDEX_W-1:0]       index;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } table_result_t;

  // tracks table contents and the results still owed by the block
  class array_table_tracker;
    logic signed [ELEM_W-1:0] cells [CAPACITY];
    int unsigned              fill;
    table_result_t            awaited[$];
    int                       errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void add_awaited(pat_status_t st, logic signed [ELEM_W-1:0] elem,
                              int unsigned slot, logic fin);
      table_result_t r;
      r.status  = st;
      r.element = elem;
      r.index   = INDEX_W'(slot);
      r.count   = COUNT_W'(fill);
      r.last    = fin;
      awaited.push_back(r);
    endfunction

    // apply one accepted item and queue the results it causes
    function void apply_request(pat_op_t op, logic signed [ELEM_W-1:0] val,
                                logic [POS_W-1:0] pos);
      int unsigned i;
      bit          hit;
      case (op)
        OP_TRAVERSE: begin
          if (fill == 0)
            add_awaited(ST_EMPTY, '0, 0, 1'b1);
          else
            for (i = 0; i < fill; i++)
              add_awaited(ST_OK, cells[i], i, (i + 1 == fill));
        end
        OP_INSERT: begin
          // fullness wins over a bad position
          if (fill >= CAPACITY) begin
            add_awaited(ST_FULL, '0, 0, 1'b1);
          end else if (pos > fill) begin
            add_awaited(ST_BADPOS, '0, 0, 1'b1);
          end else begin
            for (i = fill; i > pos; i--)
              cells[i] = cells[i - 1];
            cells[pos] = val;
            fill++;
            add_awaited(ST_OK, '0, 0, 1'b1);
          end
        end
        OP_DELETE: begin
          // emptiness wins over a bad position
          if (fill == 0) begin
            add_awaited(ST_EMPTY, '0, 0, 1'b1);
          end else if (pos >= fill) begin
            add_awaited(ST_BADPOS, '0, 0, 1'b1);
          end else begin
            for (i = pos; i + 1 < fill; i++)
              cells[i] = cells[i + 1];
            fill--;
            add_awaited(ST_OK, '0, 0, 1'b1);
          end
        end
        default: begin
          // search reports the lowest matching slot
          if (fill == 0) begin
            add_awaited(ST_EMPTY, '0, 0, 1'b1);
          end else begin
            hit = 1'b0;
            for (i = 0; i < fill && !hit; i++)
              if (cells[i] == val) begin
                add_awaited(ST_OK, cells[i], i, 1'b1);
                hit = 1'b1;
              end
            if (!hit)
              add_awaited(ST_NOTFOUND, '0, 0, 1'b1);
          end
        end
      endcase
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      // keep the log short when many results go wrong
      if (errors <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endfunction

    // compare one returned result with the oldest one owed
    function void check_reply(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected result, expected none actual status %0h element %0h",
                   $time, got.status, got.element);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        flag("status", 32'(want.status), 32'(got.status));
      if (got.element !== want.element) flag("element", want.element, got.element);
      if (got.index !== want.index)
        flag("index", 32'(want.index), 32'(got.index));
      if (got.count !== want.count)
        flag("count", 32'(want.count), 32'(got.count));
      if (got.last !== want.last)
        flag("last", 32'(want.last), 32'(got.last));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_operation;
  logic signed [ELEM_W-1:0] in_value;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic                     out_stall;
  logic [2:0]               out_status;
  logic signed [ELEM_W-1:0] out_element;
  logic [INDEX_W-1:0]       out_index;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_last;

  array_table_tracker tracker;
  table_result_t      reply;
  int                 items_sent;
  int                 burst_left;
  bit                 no_gaps;
  int                 hold_requests;
  int                 holds_done;
  int                 quiet_cycles;

  positional_array_table #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_element  (out_element),
    .out_index    (out_index),
    .out_count    (out_count),
    .out_last     (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one item, with a random gap at the start of each burst
  task automatic offer(pat_op_t op, logic signed [ELEM_W-1:0] val,
                       logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    in_position  <= pos;
    do @(posedge clk); while (in_stall);
    tracker.apply_request(op, val, pos);
    items_sent++;
  endtask

  // random item with weighted operation choice
  task automatic random_item(int w_ins, int w_del, int w_srch, int w_trav);
    int                       pick;
    pat_op_t                  op;
    logic signed [ELEM_W-1:0] val;
    logic [POS_W-1:0]         pos;
    pick = $urandom_range(0, w_ins + w_del + w_srch + w_trav - 1);
    if (pick < w_ins)                       op = OP_INSERT;
    else if (pick < w_ins + w_del)          op = OP_DELETE;
    else if (pick < w_ins + w_del + w_srch) op = OP_SEARCH;
    else                                    op = OP_TRAVERSE;
    // values: stored ones for hits and duplicates, extremes, or anything
    if (tracker.fill > 0 && $urandom_range(0, 9) < ((op == OP_SEARCH) ? 6 : 2))
      val = tracker.cells[$urandom_range(0, tracker.fill - 1)];
    else if ($urandom_range(0, 7) == 0)
      case ($urandom_range(0, 3))
        0:       val = 32'sh7fff_ffff;
        1:       val = 32'sh8000_0000;
        2:       val = '0;
        default: val = '1;
      endcase
    else
      val = $urandom;
    // positions: mostly in range, some anywhere in the field
    if ($urandom_range(0, 9) == 0 || op == OP_TRAVERSE || op == OP_SEARCH)
      pos = POS_W'($urandom_range(0, 127));
    else if (op == OP_INSERT)
      pos = POS_W'($urandom_range(0, tracker.fill));
    else
      pos = (tracker.fill == 0) ? '0 : POS_W'($urandom_range(0, tracker.fill - 1));
    offer(op, val, pos);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0)
      @(posedge clk);
  endtask

  // receiver stall pattern, with long hold-offs on request
  initial begin : receiver
    int mode;
    int mode_left;
    out_stall = 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      reply.status  = out_status;
      reply.element = out_element;
      reply.index   = out_index;
      reply.count   = out_count;
      reply.last    = out_last;
      tracker.check_reply(reply);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    int seg;
    tracker       = new();
    items_sent    = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    hold_requests = 0;
    holds_done    = 0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_TRAVERSE;
    in_value      = '0;
    in_position   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table cases
    offer(OP_TRAVERSE, '0, '0);
    offer(OP_SEARCH, 32'sh7fff_ffff, 7'd0);
    offer(OP_DELETE, '0, 7'd0);
    offer(OP_DELETE, '0, 7'h7f);
    offer(OP_INSERT, 32'sd5, 7'd1);
    offer(OP_INSERT, 32'sd5, 7'h7f);
    // directed: build a small table with extremes and a duplicate
    offer(OP_INSERT, 32'sh7fff_ffff, 7'd0);
    offer(OP_INSERT, 32'sh8000_0000, 7'd1);
    offer(OP_INSERT, '0, 7'd0);
    offer(OP_INSERT, '1, 7'd1);
    offer(OP_INSERT, 32'sh7fff_ffff, 7'd2);
    offer(OP_TRAVERSE, '1, 7'h7f);
    offer(OP_SEARCH, 32'sh7fff_ffff, '0);
    offer(OP_SEARCH, 32'sh8000_0000, '0);
    offer(OP_SEARCH, 32'sh1234_5678, '1);
    // directed: bad positions and deletes at both ends
    offer(OP_DELETE, '0, 7'd5);
    offer(OP_DELETE, '0, 7'h40);
    offer(OP_INSERT, '0, 7'd6);
    offer(OP_DELETE, '0, 7'd4);
    offer(OP_DELETE, '0, 7'd0);
    offer(OP_SEARCH, '0, '0);
    offer(OP_INSERT, 32'sh5555_5555, 7'd3);
    offer(OP_DELETE, '1, 7'd1);
    offer(OP_TRAVERSE, '0, '0);

    // fill the table, then hit it while full
    while (tracker.fill < CAPACITY)
      random_item(100, 0, 0, 0);
    repeat (3) random_item(100, 0, 0, 0);
    random_item(0, 0, 0, 1);
    repeat (5) random_item(0, 0, 1, 0);

    // long receiver hold-off while items keep coming
    hold_requests++;
    no_gaps = 1'b1;
    repeat (12) random_item(30, 30, 30, 10);
    no_gaps = 1'b0;

    // empty it out again, then poke the empty table
    while (tracker.fill > 0)
      random_item(5, 80, 10, 5);
    repeat (4) random_item(25, 25, 25, 25);
    wait_for_results();

    // random segments drifting the fill level up and down
    while (items_sent < ITEM_TOTAL) begin
      seg = $urandom_range(0, 2);
      repeat (40) begin
        case (seg)
          0:       random_item(60, 15, 15, 10);
          1:       random_item(15, 60, 15, 10);
          default: random_item(30, 30, 30, 10);
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        wait_for_results();
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
